// ===== hw/rtl/wps_pkg.sv =====
package wps_pkg;

  localparam int TS_W     = 32;
  localparam int DEB_W    = 16;
  localparam int CIRC_W   = 24;
  localparam int THR_W    = 16;
  localparam int STALE_W  = 2;
  localparam int SPEED_W  = 24;
  localparam int KMH_W    = 23;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // serial divider for circumference / period
  localparam int DIV_W     = CIRC_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [3:0]      KMH_MULT    = 4'd9;
  localparam logic [TS_W-1:0] KMH_DIVISOR = 32'd25;

  // speed*9/25 as speed*ceil(9*2^29/25) >> 29, exact for any 24-bit speed
  localparam int                    KMH_RECIP_W = 28;
  localparam logic [KMH_RECIP_W-1:0] KMH_RECIP  = 28'd193273529;
  localparam int                    KMH_SHIFT   = 29;
  localparam int                    KMH_PROD_W  = SPEED_W + KMH_RECIP_W;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd100;
  localparam logic [CIRC_W-1:0]  CIRC_RST     = 24'd1953000;
  localparam logic [THR_W-1:0]   THR_RST      = 16'd2;
  localparam logic [STALE_W-1:0] STALE_RST    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE    = 8'd3;

  typedef struct packed {
    logic edge_en;     // sensor edge word accepted
    logic div_start;
    logic spd_load;
    logic kmh_load;
    logic stale_step;
    logic avg_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic period_changed;
    logic div_done;
  } status_t;

endpackage

// ===== hw/rtl/wps_in_if.sv =====
interface wps_in_if;
  import wps_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [TS_W-1:0] timestamp_ms;
  modport source (output valid, req_type, timestamp_ms, input ready);
  modport sink   (input valid, req_type, timestamp_ms, output ready);
endinterface

// ===== hw/rtl/wps_out_if.sv =====
interface wps_out_if;
  import wps_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_um_per_ms;
  logic [KMH_W-1:0]   speed_centi_kmh;
  logic [KMH_W-1:0]   average_centi_kmh;
  logic [TS_W-1:0]    period_ms;
  modport source (output valid, speed_um_per_ms, speed_centi_kmh, average_centi_kmh,
                  period_ms, input ready);
  modport sink   (input valid, speed_um_per_ms, speed_centi_kmh, average_centi_kmh,
                  period_ms, output ready);
endinterface

// ===== hw/rtl/wps_cfg_if.sv =====
interface wps_cfg_if;
  import wps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wps_div.sv =====
module wps_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wps_pkg::DIV_W-1:0] dividend,
  input  logic [wps_pkg::TS_W-1:0]  divisor,
  output logic                      done,
  output logic [wps_pkg::DIV_W-1:0] quotient
);
  import wps_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     q_r;
  logic [TS_W-1:0]      rem_r;
  logic [TS_W-1:0]      dvs_r;

  logic [TS_W:0]   rem_sh;
  logic [TS_W:0]   diff;
  logic            take;
  logic [TS_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle; a zero divisor gives all ones
  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    take    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = take ? diff[TS_W-1:0] : rem_sh[TS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIV_W-2:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/wps_dp.sv =====
module wps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [wps_pkg::TS_W-1:0]       in_timestamp,
  input  logic                           cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wps_pkg::cmd_t                  cmd,
  output wps_pkg::status_t               status,
  output logic [wps_pkg::SPEED_W-1:0]    out_speed,
  output logic [wps_pkg::KMH_W-1:0]      out_kmh,
  output logic [wps_pkg::KMH_W-1:0]      out_avg,
  output logic [wps_pkg::TS_W-1:0]       out_period
);
  import wps_pkg::*;

  logic [DEB_W-1:0]   debounce_r;
  logic [CIRC_W-1:0]  circ_r;
  logic [THR_W-1:0]   thr_r;
  logic [STALE_W-1:0] stale_limit_r;

  logic [TS_W-1:0]    last_edge_r;
  logic [TS_W-1:0]    period_r;
  logic [TS_W-1:0]    prev_period_r;
  logic [STALE_W-1:0] stale_cnt_r;
  logic [SPEED_W-1:0] speed_r;
  logic [KMH_W-1:0]   kmh_r;
  logic [KMH_W-1:0]   avg_r;

  logic [SPEED_W-1:0] out_speed_r;
  logic [KMH_W-1:0]   out_kmh_r;
  logic [KMH_W-1:0]   out_avg_r;
  logic [TS_W-1:0]    out_period_r;

  logic [TS_W-1:0]       delta;
  logic [DIV_W-1:0]      div_dvd;
  logic [TS_W-1:0]       div_dvs;
  logic [DIV_W-1:0]      div_q;
  logic                  div_done;
  logic [KMH_PROD_W-1:0] kmh_prod;
  logic [KMH_W:0]        avg_sum;
  logic [KMH_W-1:0]      avg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      circ_r        <= CIRC_RST;
      thr_r         <= THR_RST;
      stale_limit_r <= STALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_r    <= cfg_data[DEB_W-1:0];
        REG_CIRC:     circ_r        <= cfg_data[CIRC_W-1:0];
        REG_THR:      thr_r         <= cfg_data[THR_W-1:0];
        REG_STALE:    stale_limit_r <= cfg_data[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_dvd = DIV_W'(circ_r);
  assign div_dvs = period_r;

  wps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // km/h from the registered speed by reciprocal multiply
  assign kmh_prod = KMH_PROD_W'(speed_r) * KMH_PROD_W'(KMH_RECIP);

  assign delta   = in_timestamp - last_edge_r;
  assign avg_sum = {1'b0, avg_r} + {1'b0, kmh_r};
  assign avg_nxt = avg_sum[KMH_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r   <= '0;
      period_r      <= '0;
      prev_period_r <= '0;
      stale_cnt_r   <= '0;
      speed_r       <= '0;
      kmh_r         <= '0;
      avg_r         <= '0;
    end else begin
      if (cmd.edge_en && (delta >= TS_W'(debounce_r))) begin
        period_r    <= delta;
        last_edge_r <= in_timestamp;
      end
      if (cmd.spd_load) begin
        speed_r <= div_q[SPEED_W-1:0];
      end
      if (cmd.kmh_load) begin
        kmh_r         <= kmh_prod[KMH_SHIFT +: KMH_W];
        prev_period_r <= period_r;
      end
      if (cmd.stale_step) begin
        if (stale_cnt_r >= stale_limit_r) begin
          speed_r     <= '0;
          kmh_r       <= '0;
          stale_cnt_r <= '0;
        end else begin
          stale_cnt_r <= stale_cnt_r + 1'b1;
        end
      end
      if (cmd.avg_step && (speed_r > SPEED_W'(thr_r))) begin
        avg_r <= avg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_speed_r  <= speed_r;
      out_kmh_r    <= kmh_r;
      out_avg_r    <= avg_r;
      out_period_r <= period_r;
    end
  end

  assign status.period_changed = (period_r != prev_period_r);
  assign status.div_done       = div_done;

  assign out_speed  = out_speed_r;
  assign out_kmh    = out_kmh_r;
  assign out_avg    = out_avg_r;
  assign out_period = out_period_r;

endmodule

// ===== hw/rtl/wps_ctrl.sv =====
module wps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  wps_pkg::status_t status,
  output wps_pkg::cmd_t    cmd
);
  import wps_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SPD  = 5'b00010,
    ST_KMH  = 5'b00100,
    ST_AVG  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_req_type) begin
            cmd.edge_en = 1'b1;
          end else if (status.period_changed) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_SPD;
          end else begin
            cmd.stale_step = 1'b1;
            state_nxt      = ST_AVG;
          end
        end
      end
      ST_SPD: begin
        if (status.div_done) begin
          cmd.spd_load = 1'b1;
          state_nxt    = ST_KMH;
        end
      end
      ST_KMH: begin
        // speed register holds the new quotient here
        cmd.kmh_load = 1'b1;
        state_nxt    = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg_step = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/wheel_period_speedometer.sv =====
// Wheel speedometer from sensor-edge timing.
// in_ch: words of req_type (0 = sensor edge, 1 = speed update request) and a
// millisecond timestamp. Edges update the rotation period and give no result;
// every update request gives exactly one word on out_ch (speed in um/ms, speed
// and running average in 0.01 km/h, last period in ms).
// cfg_ch: register writes (0 debounce, 1 circumference, 2 average threshold,
// 3 stale limit); always ready, to be written only while the block is idle.
// One word is in work at a time. An edge is handled without leaving the idle
// state. An update with an unchanged period passes through the average and
// output states; one with a changed period first runs the 24-step serial
// divider (circumference / period) and a constant multiply for km/h. The next
// word is taken only once the result is loaded into the output register.
// Results sit in an output register: while out_ch stalls, edges are still
// taken, and a following update finishes its work and then waits in place.
// Reset (synchronous, active low) loads the register defaults and clears all
// speed state; no clearing pass is needed.
module wheel_period_speedometer (
  input logic   clk,
  input logic   rst_n,
  wps_in_if.sink    in_ch,
  wps_out_if.source out_ch,
  wps_cfg_if.sink   cfg_ch
);
  import wps_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  wps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (status),
    .cmd         (cmd)
  );

  wps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_timestamp (in_ch.timestamp_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .cmd          (cmd),
    .status       (status),
    .out_speed    (out_ch.speed_um_per_ms),
    .out_kmh      (out_ch.speed_centi_kmh),
    .out_avg      (out_ch.average_centi_kmh),
    .out_period   (out_ch.period_ms)
  );

endmodule

// ===== dv/tb_wheel_period_speedometer.sv =====
`timescale 1ns / 1ps

module tb_wheel_period_speedometer;
  import wps_pkg::*;

  localparam bit REQ_EDGE   = 1'b0;
  localparam bit REQ_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(REG_STALE + 1);

  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int RIDE_PHASES  = 10;
  localparam int RIDE_ITEMS   = 108;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [KMH_W-1:0]   kmh;
    logic [KMH_W-1:0]   avg;
    logic [TS_W-1:0]    period;
  } reading_t;

  logic clk;
  logic rst_n;

  wps_in_if  in_if ();
  wps_out_if out_if ();
  wps_cfg_if cfg_if ();

  wheel_period_speedometer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor copy of registers and speed state
  logic [DEB_W-1:0]   debounce_ms;
  logic [CIRC_W-1:0]  circ_um;
  logic [THR_W-1:0]   avg_thr;
  logic [STALE_W-1:0] stale_lim;
  logic [TS_W-1:0]    last_edge_ms;
  logic [TS_W-1:0]    wheel_period;
  logic [TS_W-1:0]    prior_period;
  logic [STALE_W-1:0] stale_cnt;
  logic [SPEED_W-1:0] speed_now;
  logic [KMH_W-1:0]   kmh_now;
  logic [KMH_W-1:0]   kmh_avg;

  reading_t expected_readings[$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  logic [TS_W-1:0] ride_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_EDGE;
    in_if.timestamp_ms = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_DEBOUNCE;
    cfg_if.data        = '0;
    debounce_ms        = DEBOUNCE_RST;
    circ_um            = CIRC_RST;
    avg_thr            = THR_RST;
    stale_lim          = STALE_RST;
    last_edge_ms       = '0;
    wheel_period       = '0;
    prior_period       = '0;
    stale_cnt          = '0;
    speed_now          = '0;
    kmh_now            = '0;
    kmh_avg            = '0;
  end

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DEBOUNCE: debounce_ms = val[DEB_W-1:0];
      REG_CIRC:     circ_um     = val[CIRC_W-1:0];
      REG_THR:      avg_thr     = val[THR_W-1:0];
      REG_STALE:    stale_lim   = val[STALE_W-1:0];
      default: ;
    endcase
  endfunction

  // edges move the period state; updates push one expected reading
  function automatic void track_word(bit req, logic [TS_W-1:0] ts);
    logic [TS_W-1:0] delta;
    logic [TS_W-1:0] scaled;
    logic [KMH_W:0]  sum;
    reading_t r;
    if (req == REQ_EDGE) begin
      delta = ts - last_edge_ms;
      if (delta >= {16'd0, debounce_ms}) begin
        wheel_period = delta;
        last_edge_ms = ts;
      end
    end else begin
      if (wheel_period != prior_period) begin
        if (wheel_period == '0) speed_now = '1;
        else speed_now = SPEED_W'({8'd0, circ_um} / wheel_period);
        scaled  = ({8'd0, speed_now} * {28'd0, KMH_MULT}) / KMH_DIVISOR;
        kmh_now = scaled[KMH_W-1:0];
      end else if (stale_cnt >= stale_lim) begin
        speed_now = '0;
        kmh_now   = '0;
        stale_cnt = '0;
      end else begin
        stale_cnt = stale_cnt + 1'b1;
      end
      prior_period = wheel_period;
      if (speed_now > {8'd0, avg_thr}) begin
        sum     = {1'b0, kmh_avg} + {1'b0, kmh_now};
        kmh_avg = sum[KMH_W:1];
      end
      r.speed  = speed_now;
      r.kmh    = kmh_now;
      r.avg    = kmh_avg;
      r.period = wheel_period;
      expected_readings.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : check_and_track
    reading_t got;
    reading_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.speed  = out_if.speed_um_per_ms;
        got.kmh    = out_if.speed_centi_kmh;
        got.avg    = out_if.average_centi_kmh;
        got.period = out_if.period_ms;
        if (expected_readings.size() == 0) begin
          $error("result word with no update pending");
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.speed !== want.speed) begin
            $error("speed_um_per_ms: expected %0d, actual %0d", want.speed, got.speed);
            fail_count++;
          end
          if (got.kmh !== want.kmh) begin
            $error("speed_centi_kmh: expected %0d, actual %0d", want.kmh, got.kmh);
            fail_count++;
          end
          if (got.avg !== want.avg) begin
            $error("average_centi_kmh: expected %0d, actual %0d", want.avg, got.avg);
            fail_count++;
          end
          if (got.period !== want.period) begin
            $error("period_ms: expected %0d, actual %0d", want.period, got.period);
            fail_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) track_word(in_if.req_type, in_if.timestamp_ms);
    end
  end

  // receiver: random idling, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input bit req, input logic [TS_W-1:0] ts);
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= req;
    in_if.timestamp_ms <= ts;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // drop valid, drain results, then let a trailing edge word settle
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_word(REQ_UPDATE, 32'd0);           // unchanged zero period, stale count runs
    send_word(REQ_UPDATE, 32'd5);
    send_word(REQ_UPDATE, 32'd9);           // stale limit reached: clear
    send_word(REQ_EDGE, 32'd99);            // one short of debounce
    send_word(REQ_EDGE, 32'd100);           // exactly debounce
    send_word(REQ_UPDATE, 32'd120);
    send_word(REQ_EDGE, 32'hFFFF_FFFF);     // huge period, speed rounds to zero
    send_word(REQ_UPDATE, 32'hFFFF_FFFF);
    send_word(REQ_EDGE, 32'h0000_0020);     // wraps, too short
    send_word(REQ_EDGE, 32'h0000_007F);     // wraps, accepted
    send_word(REQ_UPDATE, 32'h0000_0080);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_DEBOUNCE, 24'hAB_0000);   // upper bits dropped: debounce 0
    write_reg(REG_CIRC, 24'hFF_FFFF);
    write_reg(REG_THR, 24'h00_FFFF);
    write_reg(REG_STALE, 24'hFF_FFFC);      // stale limit 0
    write_reg(REG_UNUSED, 24'h00_0001);
    write_reg('1, 24'h12_3456);
    send_word(REQ_EDGE, 32'h0000_007F);     // zero period
    send_word(REQ_UPDATE, 32'h0000_0080);   // saturated divide
    send_word(REQ_UPDATE, 32'h0000_0081);   // limit 0: clear at once
    send_word(REQ_EDGE, 32'h0000_0080);     // period 1
    send_word(REQ_UPDATE, 32'h0000_0081);
    wait_idle();
    write_reg(REG_CIRC, 24'h00_0000);
    write_reg(REG_THR, 24'h00_0000);
    write_reg(REG_STALE, 24'h00_0003);
    write_reg(REG_DEBOUNCE, 24'h00_FFFF);
    send_word(REQ_EDGE, 32'h0001_007E);     // 65534 ms: bounce
    send_word(REQ_EDGE, 32'h0001_007F);     // 65535 ms: accepted
    repeat (5) send_word(REQ_UPDATE, 32'h0001_0100);
  endtask

  task automatic test_output_stall();
    wait_idle();
    write_reg(REG_DEBOUNCE, 24'd50);
    write_reg(REG_STALE, 24'd1);
    hold_req = 1'b1;
    ride_ms = $urandom();
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) begin
        send_word(REQ_UPDATE, ride_ms + 3);
      end else begin
        ride_ms += 400 + $urandom_range(0, 1) * 37;
        send_word(REQ_EDGE, ride_ms);
      end
    end
  endtask

  task automatic test_random_rides();
    int deb;
    int base;
    int step;
    int pick;
    for (int ph = 0; ph < RIDE_PHASES; ph++) begin
      wait_idle();
      deb = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 250);
      write_reg(REG_DEBOUNCE, {8'($urandom()), 16'(deb)});
      if ($urandom_range(1)) write_reg(REG_CIRC, 24'($urandom_range(1500000, 2300000)));
      else write_reg(REG_CIRC, 24'($urandom()));
      if ($urandom_range(4) == 0) write_reg(REG_THR, 24'($urandom()));
      else write_reg(REG_THR, {8'($urandom()), 16'($urandom_range(0, 3000))});
      write_reg(REG_STALE, 24'($urandom()));
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(32'(REG_UNUSED), 255)), 24'($urandom()));
      base = ($urandom_range(4) == 0) ? $urandom_range(500000, 5000000)
                                      : deb + $urandom_range(0, 3000);
      ride_ms = $urandom();
      idle_on = (ph != 3);
      for (int n = 0; n < RIDE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          send_word(1'($urandom()), $urandom());
        end else if (pick < 50) begin
          step = $urandom_range(9);
          if (step < 6) step = base;                     // steady pedaling
          else if (step < 8) step = base + $urandom_range(0, 40) - 20;
          else step = $urandom_range(0, deb);           // contact bounce
          ride_ms += step;
          send_word(REQ_EDGE, ride_ms);
        end else begin
          send_word(REQ_UPDATE, ride_ms + $urandom_range(0, 30));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_output_stall();
    test_random_rides();
    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wps_pkg.sv
hw/rtl/wps_in_if.sv
hw/rtl/wps_out_if.sv
hw/rtl/wps_cfg_if.sv
hw/rtl/wps_div.sv
hw/rtl/wps_dp.sv
hw/rtl/wps_ctrl.sv
hw/rtl/wheel_period_speedometer.sv
dv/tb_wheel_period_speedometer.sv
